// ===== rtl/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// Shared constants, types and the rainbow color table of the LED strip
// serializer.
// ----------------------------------------------------------------------------
package rls_pkg;

    // frame geometry
    localparam int LED_COUNT   = 300;
    localparam int START_BYTES = 5;
    localparam int TAIL_BYTES  = 150;

    localparam int LED_IDX_W  = 9;
    localparam int FILL_CNT_W = 8;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;

    localparam logic [LED_IDX_W-1:0]  LED_COUNT_C = LED_IDX_W'(LED_COUNT);
    localparam logic [FILL_CNT_W:0]   START_END_C = (FILL_CNT_W + 1)'(START_BYTES);
    localparam logic [FILL_CNT_W:0]   TAIL_END_C  = (FILL_CNT_W + 1)'(TAIL_BYTES);
    localparam logic [FILL_CNT_W-1:0] TAIL_LAST_C = FILL_CNT_W'(TAIL_BYTES - 1);

    localparam logic [CHAN_W-1:0] HEADER_BYTE = 8'hFF;

    // segment table: seven entries of red, green, blue
    localparam logic [CHAN_W-1:0] RAINBOW_TAB [0:6][0:2] = '{
        '{8'd200, 8'd0,   8'd200},
        '{8'd200, 8'd0,   8'd0  },
        '{8'd200, 8'd200, 8'd0  },
        '{8'd0,   8'd200, 8'd0  },
        '{8'd0,   8'd200, 8'd200},
        '{8'd0,   8'd0,   8'd200},
        '{8'd200, 8'd0,   8'd200}
    };

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_LEDS  = 4'b0100,
        PH_TAIL  = 4'b1000
    } phase_t;

endpackage

// ===== rtl/rls_color.sv =====
// ----------------------------------------------------------------------------
// rls_color
// Rainbow color of one LED: blends two adjacent table entries by the LED's
// position inside its 32-LED segment; zero for LEDs past the lit count.
// ----------------------------------------------------------------------------
module rls_color
    import rls_pkg::*;
(
    input  logic [LED_IDX_W-1:0] led_idx,
    input  logic [LED_IDX_W-1:0] lit_count,
    output logic [COLOR_W-1:0]   color
);

    logic [3:0]  seg_raw;
    logic [2:0]  seg;
    logic [2:0]  seg_nxt;
    logic [4:0]  k;
    logic [14:0] wt_lo;
    logic [14:0] wt_hi;
    logic [COLOR_W-1:0] blend;

    assign seg_raw = led_idx[8:5];
    assign k       = led_idx[4:0];

    // segment index modulo six on a 4-bit value
    always_comb begin
        if (seg_raw >= 4'd12) begin
            seg = 3'(seg_raw - 4'd12);
        end else if (seg_raw >= 4'd6) begin
            seg = 3'(seg_raw - 4'd6);
        end else begin
            seg = 3'(seg_raw);
        end
    end

    assign seg_nxt = seg + 3'd1;
    assign wt_hi   = {10'd0, k};
    assign wt_lo   = 15'd64 - wt_hi;

    always_comb begin
        logic [14:0] a;
        logic [14:0] b;
        logic [14:0] sum;
        blend = '0;
        for (int c = 0; c < 3; c++) begin
            a   = {7'd0, RAINBOW_TAB[seg][c]};
            b   = {7'd0, RAINBOW_TAB[seg_nxt][c]};
            sum = 15'(a * wt_lo) + 15'(b * wt_hi);
            // red ends up in the top byte
            blend[(2 - c) * CHAN_W +: CHAN_W] = sum[13:6];
        end
    end

    assign color = (led_idx < lit_count) ? blend : '0;

endmodule

// ===== rtl/rainbow_led_strip_serializer_top.sv =====
// ----------------------------------------------------------------------------
// rainbow_led_strip_serializer_top
// Serializes a full LED strip frame with rainbow colors, one bit per item.
// ----------------------------------------------------------------------------
// Every accepted input item yields exactly one result item, one per clock when
// both sides are ready. While idle, an item with s_start_req high starts a frame
// and already carries its first bit; the frame then takes
// (START_BYTES + 4 * LED_COUNT + TAIL_BYTES) * 8 items (10,840 with the default
// 300 LEDs), one data bit each, MSB first. Items that arrive while idle
// without a start give a result with m_bit_valid low, and start requests during
// a frame are ignored. The color of each LED is computed when its 0xFF header
// byte is loaded, from the lit count held at that moment, so cfg_wr_data takes
// effect from the next LED not yet begun. The result register decouples the
// two channels, so a new item is taken in the same cycle a waiting result is
// taken.
module rainbow_led_strip_serializer_top
    import rls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LED_IDX_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_data_bit,
    output logic                 m_bit_valid,
    output logic                 m_frame_last
);

    phase_t                phase_reg, phase_next;
    logic [LED_IDX_W-1:0]  led_cnt_reg, led_cnt_next;
    logic [1:0]            byte_in_led_reg, byte_in_led_next;
    logic [2:0]            bit_cnt_reg, bit_cnt_next;
    logic [FILL_CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CHAN_W-1:0]     shift_reg, shift_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [LED_IDX_W-1:0]  num_lit_reg;

    logic m_valid_reg, m_valid_next;
    logic m_data_bit_reg, m_data_bit_next;
    logic m_bit_valid_reg, m_bit_valid_next;
    logic m_frame_last_reg, m_frame_last_next;

    logic                  accept;
    logic                  active;
    phase_t                eff_phase;
    logic [FILL_CNT_W-1:0] eff_fill;
    logic [2:0]            eff_bit;
    logic [CHAN_W-1:0]     eff_shift;
    logic [LED_IDX_W:0]    led_inc;
    logic [FILL_CNT_W:0]   fill_inc;
    logic [LED_IDX_W-1:0]  lit_sat;
    logic [LED_IDX_W-1:0]  begin_idx;
    logic [COLOR_W-1:0]    begin_color;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign lit_sat = (num_lit_reg > LED_COUNT_C) ? LED_COUNT_C : num_lit_reg;

    // a start while idle behaves as the first bit of the start bytes
    assign active    = (phase_reg != PH_IDLE) || s_start_req;
    assign eff_phase = (phase_reg == PH_IDLE) ? PH_START : phase_reg;
    assign eff_fill  = (phase_reg == PH_IDLE) ? '0 : fill_cnt_reg;
    assign eff_bit   = (phase_reg == PH_IDLE) ? '0 : bit_cnt_reg;
    assign eff_shift = (phase_reg == PH_IDLE) ? '0 : shift_reg;

    assign led_inc  = {1'b0, led_cnt_reg} + (LED_IDX_W + 1)'(1);
    assign fill_inc = {1'b0, eff_fill} + (FILL_CNT_W + 1)'(1);

    // the first LED starts from the start bytes, the others from the previous LED
    assign begin_idx = (eff_phase == PH_START) ? '0 : led_inc[LED_IDX_W-1:0];

    rls_color u_color (
        .led_idx   (begin_idx),
        .lit_count (lit_sat),
        .color     (begin_color)
    );

    always_comb begin
        phase_next        = phase_reg;
        led_cnt_next      = led_cnt_reg;
        byte_in_led_next  = byte_in_led_reg;
        bit_cnt_next      = bit_cnt_reg;
        fill_cnt_next     = fill_cnt_reg;
        shift_next        = shift_reg;
        color_next        = color_reg;
        m_valid_next      = m_valid_reg;
        m_data_bit_next   = m_data_bit_reg;
        m_bit_valid_next  = m_bit_valid_reg;
        m_frame_last_next = m_frame_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next      = 1'b1;
            m_data_bit_next   = 1'b0;
            m_bit_valid_next  = 1'b0;
            m_frame_last_next = 1'b0;

            if (active) begin
                m_data_bit_next   = eff_shift[7];
                m_bit_valid_next  = 1'b1;
                m_frame_last_next = (eff_phase == PH_TAIL) && (eff_fill == TAIL_LAST_C)
                                    && (eff_bit == 3'd7);

                phase_next    = eff_phase;
                fill_cnt_next = eff_fill;
                shift_next    = {eff_shift[6:0], 1'b0};
                bit_cnt_next  = eff_bit + 3'd1;

                // byte boundary
                if (eff_bit == 3'd7) begin
                    unique case (eff_phase)
                        PH_START: begin
                            fill_cnt_next = fill_inc[FILL_CNT_W-1:0];
                            if (fill_inc >= START_END_C) begin
                                phase_next       = PH_LEDS;
                                led_cnt_next     = '0;
                                color_next       = begin_color;
                                byte_in_led_next = 2'd0;
                                shift_next       = HEADER_BYTE;
                            end else begin
                                shift_next = '0;
                            end
                        end
                        PH_LEDS: begin
                            if (byte_in_led_reg == 2'd3) begin
                                led_cnt_next = led_inc[LED_IDX_W-1:0];
                                if (led_inc >= {1'b0, LED_COUNT_C}) begin
                                    phase_next       = PH_TAIL;
                                    fill_cnt_next    = '0;
                                    byte_in_led_next = 2'd0;
                                    shift_next       = '0;
                                end else begin
                                    color_next       = begin_color;
                                    byte_in_led_next = 2'd0;
                                    shift_next       = HEADER_BYTE;
                                end
                            end else begin
                                byte_in_led_next = byte_in_led_reg + 2'd1;
                                unique case (byte_in_led_reg)
                                    2'd0:    shift_next = color_reg[23:16];
                                    2'd1:    shift_next = color_reg[15:8];
                                    default: shift_next = color_reg[7:0];
                                endcase
                            end
                        end
                        PH_TAIL: begin
                            fill_cnt_next = fill_inc[FILL_CNT_W-1:0];
                            shift_next    = '0;
                            if (fill_inc >= TAIL_END_C) begin
                                phase_next    = PH_IDLE;
                                fill_cnt_next = '0;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            led_cnt_reg     <= '0;
            byte_in_led_reg <= '0;
            bit_cnt_reg     <= '0;
            fill_cnt_reg    <= '0;
            shift_reg       <= '0;
            color_reg       <= '0;
            num_lit_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            led_cnt_reg     <= led_cnt_next;
            byte_in_led_reg <= byte_in_led_next;
            bit_cnt_reg     <= bit_cnt_next;
            fill_cnt_reg    <= fill_cnt_next;
            shift_reg       <= shift_next;
            color_reg       <= color_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                num_lit_reg <= cfg_wr_data;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_bit_reg   <= m_data_bit_next;
        m_bit_valid_reg  <= m_bit_valid_next;
        m_frame_last_reg <= m_frame_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_data_bit   = m_data_bit_reg;
    assign m_bit_valid  = m_bit_valid_reg;
    assign m_frame_last = m_frame_last_reg;

endmodule

// ===== verif/rainbow_led_strip_serializer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_led_strip_serializer_top_tb
// Runs the start bytes and the first LEDs of a frame through the serializer,
// changing the lit count between chunks, with bursty input and a stalling
// output, and checks every serial bit against a cycle-free model of the
// frame layout and rainbow blend.
// ----------------------------------------------------------------------------
module rainbow_led_strip_serializer_top_tb;
    import rls_pkg::*;

    localparam int CHUNK_ITEMS    = 92;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 200;
    localparam int NUM_PLANS      = 6;

    localparam logic [7:0] LED_HEADER = 8'hFF;

    localparam int HUE_TAB [0:6][0:2] = '{
        '{200, 0,   200},
        '{200, 0,   0  },
        '{200, 200, 0  },
        '{0,   200, 0  },
        '{0,   200, 200},
        '{0,   0,   200},
        '{200, 0,   200}
    };

    typedef struct packed {
        logic data_bit;
        logic bit_valid;
        logic frame_last;
    } serial_bit_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [LED_IDX_W-1:0] cfg_wr_data  = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_start_req  = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic                 m_data_bit;
    logic                 m_bit_valid;
    logic                 m_frame_last;

    rainbow_led_strip_serializer_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_req  (s_start_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_bit   (m_data_bit),
        .m_bit_valid  (m_bit_valid),
        .m_frame_last (m_frame_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // serializer model state
    phase_t               ser_phase;
    logic [LED_IDX_W-1:0] ser_led;
    logic [1:0]           ser_byte;
    logic [2:0]           ser_bit;
    logic [7:0]           ser_fill;
    logic [7:0]           ser_shift;
    logic [COLOR_W-1:0]   ser_color;
    logic [LED_IDX_W-1:0] lit_cfg;

    logic        start_req_q [$];
    serial_bit_t bit_expect_q [$];
    serial_bit_t next_bit;

    int burst_left   = 1;
    int gap_left     = 0;
    int mismatch_cnt = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    logic [9:0] rx_cycle = '0;

    function automatic logic [COLOR_W-1:0] rainbow_color(input logic [LED_IDX_W-1:0] idx);
        int seg;
        int k;
        int ch;
        logic [COLOR_W-1:0] rgb;
        seg = (idx >> 5) % 6;
        k   = idx & 31;
        rgb = '0;
        for (ch = 0; ch < 3; ch++) begin
            rgb = {rgb[15:0],
                   8'((HUE_TAB[seg][ch] * (64 - k) + HUE_TAB[seg + 1][ch] * k) / 64)};
        end
        return rgb;
    endfunction

    // color is latched when the header byte of each led is loaded
    task automatic load_led_header();
        logic [LED_IDX_W-1:0] lit;
        lit       = (lit_cfg > LED_COUNT) ? LED_IDX_W'(LED_COUNT) : lit_cfg;
        ser_color = (ser_led < lit) ? rainbow_color(ser_led) : '0;
        ser_byte  = '0;
        ser_shift = LED_HEADER;
    endtask

    task automatic advance_serializer(input logic start, output serial_bit_t res);
        res = '0;
        if (ser_phase == PH_IDLE && start) begin
            ser_phase = PH_START;
            ser_fill  = '0;
            ser_bit   = '0;
            ser_shift = '0;
        end
        if (ser_phase != PH_IDLE) begin
            res.data_bit   = ser_shift[7];
            res.bit_valid  = 1'b1;
            res.frame_last = (ser_phase == PH_TAIL) && (ser_fill == TAIL_BYTES - 1) &&
                             (ser_bit == 3'd7);
            ser_shift = ser_shift << 1;
            if (ser_bit != 3'd7) begin
                ser_bit = ser_bit + 3'd1;
            end else begin
                ser_bit = '0;
                case (ser_phase)
                    PH_START: begin
                        ser_fill = ser_fill + 8'd1;
                        if (ser_fill >= START_BYTES) begin
                            ser_phase = PH_LEDS;
                            ser_led   = '0;
                            load_led_header();
                        end else begin
                            ser_shift = '0;
                        end
                    end
                    PH_LEDS: begin
                        if (ser_byte == 2'd3) begin
                            ser_led = ser_led + 1'b1;
                            if (ser_led >= LED_COUNT) begin
                                ser_phase = PH_TAIL;
                                ser_fill  = '0;
                                ser_byte  = '0;
                                ser_shift = '0;
                            end else begin
                                load_led_header();
                            end
                        end else begin
                            ser_byte  = ser_byte + 2'd1;
                            ser_shift = 8'(ser_color >> (8 * (3 - ser_byte)));
                        end
                    end
                    default: begin
                        ser_fill  = ser_fill + 8'd1;
                        ser_shift = '0;
                        if (ser_fill >= TAIL_BYTES) begin
                            ser_phase = PH_IDLE;
                            ser_fill  = '0;
                        end
                    end
                endcase
            end
        end
    endtask

    // a chunk of items, start held high or random; starts mid-frame are ignored
    task automatic queue_items(input int count, input bit hold_start);
        int n;
        for (n = 0; n < count; n++) begin
            start_req_q.push_back(hold_start ? 1'b1 : 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (start_req_q.size() != 0 || s_valid || bit_expect_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // driver: bursts of items with random gaps, model runs on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_serializer(s_start_req, next_bit);
                bit_expect_q.push_back(next_bit);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (start_req_q.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_start_req <= start_req_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 64);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern steps through four modes on a free-running cycle counter, plus one long hold-off
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            case (rx_cycle[9:8])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= 1'($urandom_range(0, 1));
                2'd2:    m_ready <= (rx_cycle[2:0] < 3'd5);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor: each result item against the oldest expectation
    always @(posedge aclk) begin
        serial_bit_t want;
        int errs;
        errs = 0;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (bit_expect_q.size() == 0) begin
                $display("%0t: unexpected result data_bit=%0b bit_valid=%0b frame_last=%0b",
                         $time, m_data_bit, m_bit_valid, m_frame_last);
                errs++;
            end else begin
                want = bit_expect_q.pop_front();
                if (m_data_bit !== want.data_bit) begin
                    $display("%0t: data_bit expected %0b actual %0b",
                             $time, want.data_bit, m_data_bit);
                    errs++;
                end
                if (m_bit_valid !== want.bit_valid) begin
                    $display("%0t: bit_valid expected %0b actual %0b",
                             $time, want.bit_valid, m_bit_valid);
                    errs++;
                end
                if (m_frame_last !== want.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, want.frame_last, m_frame_last);
                    errs++;
                end
            end
            if (errs != 0) begin
                mismatch_cnt <= mismatch_cnt + errs;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int lit_plan [NUM_PLANS];
        int p;
        ser_phase = PH_IDLE;
        ser_led   = '0;
        ser_byte  = '0;
        ser_bit   = '0;
        ser_fill  = '0;
        ser_shift = '0;
        ser_color = '0;
        lit_cfg   = '0;
        // above led count saturates, then full, single, partial, above count again, and dark strips
        lit_plan = '{511, LED_COUNT, 1, $urandom_range(2, LED_COUNT - 1),
                     $urandom_range(LED_COUNT + 1, 510), 0};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle ticks first, then the frame starts with the reset lit count
        start_req_q.push_back(1'b0);
        start_req_q.push_back(1'b0);
        start_req_q.push_back(1'b0);
        queue_items(CHUNK_ITEMS, 1'b1);

        for (p = 0; p < NUM_PLANS; p++) begin
            wait_drained();
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= LED_IDX_W'(lit_plan[p]);
            lit_cfg      = LED_IDX_W'(lit_plan[p]);
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(negedge aclk);
            queue_items(CHUNK_ITEMS, 1'b0);
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== rainbow_led_strip_serializer_top.f =====
rtl/rls_pkg.sv
rtl/rls_color.sv
rtl/rainbow_led_strip_serializer_top.sv
verif/rainbow_led_strip_serializer_top_tb.sv
